FILE: hw/rtl/segal_pkg.sv
`timescale 1ns / 1ps

package segal_pkg;

   localparam int SEGMENTS_DEF = 16;
   localparam int MAX_RESULTS  = 16;
   localparam int EMIT_W       = $clog2(MAX_RESULTS);

   localparam int CMD_W    = 3;
   localparam int ID_W     = 16;
   localparam int LEN_W    = 5;
   localparam int LIM_W    = 16;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 4;
   localparam int USED_W   = 5;

   localparam logic [CMD_W-1:0] CMD_INSERT    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_BLOCK     = 3'd1;
   localparam logic [CMD_W-1:0] CMD_FREE      = 3'd2;
   localparam logic [CMD_W-1:0] CMD_TICK      = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CHK_TIME  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_CHK_QUANT = 3'd5;
   localparam logic [CMD_W-1:0] CMD_RESET_ALL = 3'd6;

   localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STS_NO_SPACE  = 2'd1;
   localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] STS_NONE      = 2'd3;

   localparam logic [LIM_W-1:0] ELAPSED_MAX = 16'hFFFF;

   typedef struct packed {
      logic [ID_W-1:0]  owner;
      logic [LIM_W-1:0] elapsed;
      logic [LIM_W-1:0] time_limit;
      logic [LIM_W-1:0] quantum_limit;
   } entry_type;

endpackage

FILE: hw/rtl/segal_mem.sv
`timescale 1ns / 1ps

module segal_mem #(
   parameter int SEGMENTS = segal_pkg::SEGMENTS_DEF
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [$clog2(SEGMENTS)-1:0] wr_addr,
   input  segal_pkg::entry_type        wr_data,
   input  logic [$clog2(SEGMENTS)-1:0] rd_addr,
   output segal_pkg::entry_type        rd_data
);

   segal_pkg::entry_type mem_ff [SEGMENTS];
   segal_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/segment_allocator_with_timeouts_top.sv
`timescale 1ns / 1ps
// First-fit segment allocator with per-owner timeouts. Issue one command beat
// with start while busy is low; busy then stays high until the command's last
// result has been shown. Results come out on the rsp_ ports for one cycle each,
// marked by rsp_valid, and cannot be held off, so capture every strobe. A check
// command gives one beat per expired slot (the quantum check skips a slot whose
// previous slot has the same owner), at most sixteen, with rsp_last on the
// final one, or a single beat with status "nothing found"; every other command
// gives one beat. Slot data sit in a one-port-write, one-port-read synchronous
// memory: block, free, tick and the two checks walk the slots with a read state
// and then an evaluate-and-write-back state per slot. Insert scans the valid
// bits at one slot a cycle and then writes one slot a cycle. Reset all and
// unused codes go straight to the result beat. No clearing pass is needed after
// reset: valid and blocked bits live in flops and are cleared at once.

module segment_allocator_with_timeouts_top #(
   parameter int SEGMENTS = segal_pkg::SEGMENTS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [segal_pkg::CMD_W-1:0]    req_command,
   input  logic [segal_pkg::ID_W-1:0]     req_process_id,
   input  logic [segal_pkg::LEN_W-1:0]    req_length,
   input  logic [segal_pkg::LIM_W-1:0]    req_time_limit,
   input  logic [segal_pkg::LIM_W-1:0]    req_quantum_limit,
   output logic                           rsp_valid,
   output logic [segal_pkg::STATUS_W-1:0] rsp_status,
   output logic [segal_pkg::POS_W-1:0]    rsp_position,
   output logic [segal_pkg::ID_W-1:0]     rsp_expired_id,
   output logic [segal_pkg::USED_W-1:0]   rsp_used_slots,
   output logic                           rsp_last
);

   localparam int IDX_W = $clog2(SEGMENTS);
   localparam int CNT_W = $clog2(SEGMENTS + 1);
   localparam int CMP_W = ((CNT_W > segal_pkg::LEN_W) ? CNT_W : segal_pkg::LEN_W) + 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_SCAN,
      ST_INS_WR,
      ST_RD,
      ST_EV,
      ST_CHK_END,
      ST_RESP
   } state_type;

   state_type state_ff, state_in;

   // command beat held for the whole walk
   logic [segal_pkg::CMD_W-1:0]    cmd_ff, cmd_in;
   logic [segal_pkg::ID_W-1:0]     id_ff, id_in;
   logic [segal_pkg::LEN_W-1:0]    len_ff, len_in;
   logic [segal_pkg::LIM_W-1:0]    tlim_ff, tlim_in;
   logic [segal_pkg::LIM_W-1:0]    qlim_ff, qlim_in;

   // walk control
   logic [CNT_W-1:0]               idx_ff, idx_in;
   logic [CNT_W-1:0]               run_ff, run_in;
   logic [IDX_W-1:0]               start_ff, start_in;
   logic                           found_ff, found_in;
   logic                           prev_valid_ff, prev_valid_in;
   logic [segal_pkg::ID_W-1:0]     prev_owner_ff, prev_owner_in;
   logic                           pend_ff, pend_in;
   logic [segal_pkg::ID_W-1:0]     pend_id_ff, pend_id_in;
   logic [segal_pkg::EMIT_W-1:0]   emitted_ff, emitted_in;
   logic [segal_pkg::STATUS_W-1:0] status_ff, status_in;

   // table state kept in flops
   logic [SEGMENTS-1:0]            valid_ff, valid_in;
   logic [SEGMENTS-1:0]            blocked_ff, blocked_in;
   logic [CNT_W-1:0]               used_ff, used_in;

   // result registers
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [segal_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [segal_pkg::POS_W-1:0]    rsp_position_ff, rsp_position_in;
   logic [segal_pkg::ID_W-1:0]     rsp_expired_id_ff, rsp_expired_id_in;
   logic [segal_pkg::USED_W-1:0]   rsp_used_slots_ff, rsp_used_slots_in;
   logic                           rsp_last_ff, rsp_last_in;

   // memory port
   logic                           wr_en;
   logic [IDX_W-1:0]               wr_addr;
   segal_pkg::entry_type           wr_data;
   segal_pkg::entry_type           rd_data;

   logic [IDX_W-1:0]               si;
   logic                           last_slot;
   logic                           match;
   logic                           walk_ok;
   logic                           is_quant;
   logic                           hit;
   logic [CMP_W-1:0]               run_ext;
   logic [CMP_W-1:0]               first_ext;

   assign si        = idx_ff[IDX_W-1:0];
   assign last_slot = (idx_ff == CNT_W'(SEGMENTS - 1));
   assign match     = valid_ff[si] && (rd_data.owner == id_ff);
   assign walk_ok   = (cmd_ff == segal_pkg::CMD_FREE) ? blocked_ff[si] : !blocked_ff[si];
   assign is_quant  = (cmd_ff == segal_pkg::CMD_CHK_QUANT);
   assign run_ext   = CMP_W'(run_ff) + CMP_W'(1);
   assign first_ext = CMP_W'(idx_ff) + CMP_W'(1) - CMP_W'(len_ff);

   always_comb begin
      if (is_quant) begin
         hit = valid_ff[si]
            && !(prev_valid_ff && (prev_owner_ff == rd_data.owner))
            && (rd_data.elapsed >= rd_data.quantum_limit);
      end else begin
         hit = valid_ff[si] && (rd_data.elapsed >= rd_data.time_limit);
      end
   end

   always_comb begin
      state_in          = state_ff;
      cmd_in            = cmd_ff;
      id_in             = id_ff;
      len_in            = len_ff;
      tlim_in           = tlim_ff;
      qlim_in           = qlim_ff;
      idx_in            = idx_ff;
      run_in            = run_ff;
      start_in          = start_ff;
      found_in          = found_ff;
      prev_valid_in     = prev_valid_ff;
      prev_owner_in     = prev_owner_ff;
      pend_in           = pend_ff;
      pend_id_in        = pend_id_ff;
      emitted_in        = emitted_ff;
      status_in         = status_ff;
      valid_in          = valid_ff;
      blocked_in        = blocked_ff;
      used_in           = used_ff;
      rsp_valid_in      = 1'b0;
      rsp_status_in     = rsp_status_ff;
      rsp_position_in   = rsp_position_ff;
      rsp_expired_id_in = rsp_expired_id_ff;
      rsp_used_slots_in = rsp_used_slots_ff;
      rsp_last_in       = rsp_last_ff;
      wr_en             = 1'b0;
      wr_addr           = si;
      wr_data           = rd_data;

      case (state_ff)
         ST_IDLE: begin
            if (start && !busy) begin
               cmd_in        = req_command;
               id_in         = req_process_id;
               len_in        = req_length;
               tlim_in       = req_time_limit;
               qlim_in       = req_quantum_limit;
               idx_in        = '0;
               run_in        = '0;
               start_in      = '0;
               found_in      = 1'b0;
               prev_valid_in = 1'b0;
               pend_in       = 1'b0;
               emitted_in    = '0;
               status_in     = segal_pkg::STS_OK;
               case (req_command)
                  segal_pkg::CMD_INSERT: begin
                     if (req_length == '0 || used_ff >= CNT_W'(SEGMENTS)) begin
                        status_in = segal_pkg::STS_NO_SPACE;
                        state_in  = ST_RESP;
                     end else begin
                        state_in = ST_INS_SCAN;
                     end
                  end
                  segal_pkg::CMD_BLOCK, segal_pkg::CMD_FREE, segal_pkg::CMD_TICK,
                  segal_pkg::CMD_CHK_TIME, segal_pkg::CMD_CHK_QUANT: begin
                     state_in = ST_RD;
                  end
                  segal_pkg::CMD_RESET_ALL: begin
                     valid_in   = '0;
                     blocked_in = '0;
                     used_in    = '0;
                     state_in   = ST_RESP;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end

         // first fit over the valid bits, one slot a cycle
         ST_INS_SCAN: begin
            if (valid_ff[si]) begin
               run_in = '0;
            end else begin
               run_in = run_ff + CNT_W'(1);
            end
            if (!valid_ff[si] && run_ext >= CMP_W'(len_ff)) begin
               start_in = first_ext[IDX_W-1:0];
               idx_in   = CNT_W'(first_ext);
               run_in   = CNT_W'(len_ff - segal_pkg::LEN_W'(1));
               state_in = ST_INS_WR;
            end else if (last_slot) begin
               status_in = segal_pkg::STS_NO_SPACE;
               state_in  = ST_RESP;
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end

         // fill the run, one slot a cycle
         ST_INS_WR: begin
            wr_en                 = 1'b1;
            wr_data.owner         = id_ff;
            wr_data.elapsed       = '0;
            wr_data.time_limit    = tlim_ff;
            wr_data.quantum_limit = qlim_ff;
            valid_in[si]          = 1'b1;
            blocked_in[si]        = 1'b0;
            if (run_ff == '0) begin
               used_in  = used_ff + CNT_W'(len_ff);
               state_in = ST_RESP;
            end else begin
               run_in = run_ff - CNT_W'(1);
               idx_in = idx_ff + CNT_W'(1);
            end
         end

         ST_RD: begin
            state_in = ST_EV;
         end

         ST_EV: begin
            state_in = ST_RD;
            case (cmd_ff)
               segal_pkg::CMD_BLOCK, segal_pkg::CMD_FREE: begin
                  if (match && walk_ok) begin
                     found_in = 1'b1;
                     if (cmd_ff == segal_pkg::CMD_FREE) begin
                        valid_in[si]   = 1'b0;
                        blocked_in[si] = 1'b0;
                        if (used_ff != '0) begin
                           used_in = used_ff - CNT_W'(1);
                        end
                     end else begin
                        blocked_in[si] = 1'b1;
                     end
                     if (last_slot) begin
                        state_in = ST_RESP;
                     end else begin
                        idx_in = idx_ff + CNT_W'(1);
                     end
                  end else if (match || found_ff) begin
                     state_in = ST_RESP;
                  end else if (last_slot) begin
                     status_in = segal_pkg::STS_NOT_FOUND;
                     state_in  = ST_RESP;
                  end else begin
                     idx_in = idx_ff + CNT_W'(1);
                  end
               end
               segal_pkg::CMD_TICK: begin
                  if (valid_ff[si] && rd_data.elapsed != segal_pkg::ELAPSED_MAX) begin
                     wr_en           = 1'b1;
                     wr_data.elapsed = rd_data.elapsed + segal_pkg::LIM_W'(1);
                  end
                  if (last_slot) begin
                     state_in = ST_RESP;
                  end else begin
                     idx_in = idx_ff + CNT_W'(1);
                  end
               end
               default: begin
                  // checks: hold one hit back so the final beat can carry last
                  prev_valid_in = valid_ff[si];
                  prev_owner_in = rd_data.owner;
                  if (hit) begin
                     pend_in    = 1'b1;
                     pend_id_in = rd_data.owner;
                     if (pend_ff) begin
                        rsp_valid_in      = 1'b1;
                        rsp_status_in     = segal_pkg::STS_OK;
                        rsp_position_in   = '0;
                        rsp_expired_id_in = pend_id_ff;
                        rsp_used_slots_in = segal_pkg::USED_W'(used_ff);
                        rsp_last_in       = 1'b0;
                        emitted_in        = emitted_ff + segal_pkg::EMIT_W'(1);
                     end
                  end
                  if (hit && pend_ff &&
                      emitted_ff == segal_pkg::EMIT_W'(segal_pkg::MAX_RESULTS - 1)) begin
                     // seventeenth hit: the sixteenth goes out as the final beat, drop the rest
                     rsp_last_in = 1'b1;
                     state_in    = ST_IDLE;
                  end else if (last_slot) begin
                     state_in = ST_CHK_END;
                  end else begin
                     idx_in = idx_ff + CNT_W'(1);
                  end
               end
            endcase
         end

         ST_CHK_END: begin
            rsp_valid_in      = 1'b1;
            rsp_position_in   = '0;
            rsp_used_slots_in = segal_pkg::USED_W'(used_ff);
            rsp_last_in       = 1'b1;
            if (pend_ff) begin
               rsp_status_in     = segal_pkg::STS_OK;
               rsp_expired_id_in = pend_id_ff;
            end else begin
               rsp_status_in     = segal_pkg::STS_NONE;
               rsp_expired_id_in = '0;
            end
            state_in = ST_IDLE;
         end

         ST_RESP: begin
            rsp_valid_in      = 1'b1;
            rsp_status_in     = status_ff;
            rsp_expired_id_in = '0;
            rsp_used_slots_in = segal_pkg::USED_W'(used_ff);
            rsp_last_in       = 1'b1;
            if (cmd_ff == segal_pkg::CMD_INSERT && status_ff == segal_pkg::STS_OK) begin
               rsp_position_in = segal_pkg::POS_W'(start_ff);
            end else begin
               rsp_position_in = '0;
            end
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         blocked_ff   <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         emitted_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         blocked_ff   <= blocked_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
         pend_ff      <= pend_in;
         emitted_ff   <= emitted_in;
      end
      cmd_ff            <= cmd_in;
      id_ff             <= id_in;
      len_ff            <= len_in;
      tlim_ff           <= tlim_in;
      qlim_ff           <= qlim_in;
      idx_ff            <= idx_in;
      run_ff            <= run_in;
      start_ff          <= start_in;
      prev_valid_ff     <= prev_valid_in;
      prev_owner_ff     <= prev_owner_in;
      pend_id_ff        <= pend_id_in;
      status_ff         <= status_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_position_ff   <= rsp_position_in;
      rsp_expired_id_ff <= rsp_expired_id_in;
      rsp_used_slots_ff <= rsp_used_slots_in;
      rsp_last_ff       <= rsp_last_in;
   end

   segal_mem #(
      .SEGMENTS (SEGMENTS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (si),
      .rd_data (rd_data)
   );

   // busy also covers the cycle that shows a final beat
   assign busy           = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_position   = rsp_position_ff;
   assign rsp_expired_id = rsp_expired_id_ff;
   assign rsp_used_slots = rsp_used_slots_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

FILE: hw/rtl/segal_checker.sv
`timescale 1ns / 1ps

module segal_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           rsp_valid,
   input logic [segal_pkg::STATUS_W-1:0] rsp_status,
   input logic [segal_pkg::POS_W-1:0]    rsp_position,
   input logic                           rsp_last
);

   // a beat only comes out while a command is in flight
   a_rsp_in_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result beat outside a command");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted command did not raise busy");

   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |=> !rsp_valid)
      else $error("beat after final beat");

   a_err_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != segal_pkg::STS_OK) |-> rsp_last)
      else $error("non-ok status on a non-final beat");

   a_nospace_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == segal_pkg::STS_NO_SPACE) |-> (rsp_position == '0))
      else $error("failed insert reports a position");

endmodule

bind segment_allocator_with_timeouts_top segal_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_valid    (rsp_valid),
   .rsp_status   (rsp_status),
   .rsp_position (rsp_position),
   .rsp_last     (rsp_last)
);
